>>> src/cft_pkg.sv
package cft_pkg;

	localparam int NumBuckets  = 1024;
	localparam int BucketBits  = 10;
	localparam int Slots       = 4;
	localparam int SlotBits    = 2;
	localparam int KickLimit   = 500;
	localparam int KickBits    = 9;
	localparam int FpBits      = 16;
	localparam int CountBits   = 13;
	localparam int RowBits     = FpBits * Slots;

	localparam logic [31:0] ALT_MULT   = 32'h5bd1e995;
	localparam logic [15:0] LFSR_TAPS  = 16'hB400;
	localparam logic [15:0] SEED_RESET = 16'd44257;
	localparam logic [3:0]  IDX_BITS_RESET = 4'd10;
	localparam logic [CountBits-1:0] COUNT_MAX = 13'd8191;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_LOOKUP = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	localparam logic [0:0] CFG_IDX_BITS = 1'b0;
	localparam logic [0:0] CFG_SEED     = 1'b1;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] key_hash;
	} req_t;

	typedef struct packed {
		logic                 success;
		logic [CountBits-1:0] item_count;
	} rsp_t;

	typedef struct packed {
		logic [1:0]            action;
		logic [FpBits-1:0]     fp;
		logic [BucketBits-1:0] i1;
		logic [BucketBits-1:0] i2;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  idx_bits;
		logic        seed_load;
		logic [15:0] seed;
	} cfg_t;

	// mask to configured width, then truncate to the table index width
	function automatic logic [BucketBits-1:0] reduce_idx(input logic [31:0] v,
			input logic [3:0] nbits);
		logic [31:0] m;
		m = (32'd1 << nbits) - 32'd1;
		return BucketBits'(v & m);
	endfunction

	function automatic logic [15:0] lfsr_step(input logic [15:0] v);
		return v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
	endfunction

endpackage

>>> src/cuckoo_filter_table.sv
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_ready   | action, key_hash
// out     | output    | out_valid/out_ready | success, item_count
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
// lookup/remove: primary then alternate bucket, via the bucket row memory with one read and one write port
// insert: takes a free slot in either bucket, else evicts fingerprints, up to 500 evictions
// after reset the table is cleared one bucket a cycle, all 1024 buckets
// up to four items wait in the front stages and queue while the back end is busy
module cuckoo_filter_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cft_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output cft_pkg::rsp_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [0:0]    cfg_index,
	input  logic [15:0]   cfg_data
);
	logic [3:0]    idx_bits_q;
	cft_pkg::cfg_t cfg;
	logic          fq_valid, fq_ready, bq_valid, bq_ready;
	cft_pkg::cmd_t fq_data, bq_data;

	assign cfg_ready = 1'b1;

	// index-width configuration register; the seed is loaded in the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_bits_q <= cft_pkg::IDX_BITS_RESET;
		end else if (cfg_valid && cfg_index == cft_pkg::CFG_IDX_BITS) begin
			idx_bits_q <= cfg_data[3:0];
		end
	end

	assign cfg.idx_bits  = idx_bits_q;
	assign cfg.seed_load = cfg_valid && cfg_index == cft_pkg::CFG_SEED;
	assign cfg.seed      = cfg_data;

	cft_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.idx_bits(idx_bits_q),
		.q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
	);

	cft_queue u_queue (
		.clk, .arst_n,
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
		.rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
	);

	cft_back u_back (
		.clk, .arst_n, .cfg,
		.c_valid(bq_valid), .c_ready(bq_ready), .c_data(bq_data),
		.out_valid, .out_ready, .out_data
	);

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> !out_valid)
		else $error("result repeated");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(bq_valid && bq_ready) |-> !out_valid)
		else $error("command taken while result pending");
	a_seed_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cfg.seed_load) |-> u_back.lfsr_q != 16'd0)
		else $error("lfsr locked");
endmodule

>>> src/cft_front.sv
module cft_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cft_pkg::req_t       in_data,
	input  logic [3:0]          idx_bits,
	output logic                q_valid,
	input  logic                q_ready,
	output cft_pkg::cmd_t       q_data
);
	// stage 1 registers action, fingerprint, primary index and fingerprint product
	logic                          v_s1;
	logic [1:0]                    act_s1;
	logic [cft_pkg::FpBits-1:0]    fp_s1;
	logic [cft_pkg::BucketBits-1:0] i1_s1;
	logic [31:0]                   prod_s1;
	logic [cft_pkg::FpBits-1:0]    fp_c;
	logic                          adv;

	assign fp_c = (in_data.key_hash[15:0] == 16'd0) ? 16'd1 : in_data.key_hash[15:0];
	assign adv  = !v_s1 || q_ready || !q_valid;
	assign in_ready = !v_s1 || (q_ready || !q_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			act_s1  <= in_data.action;
			fp_s1   <= fp_c;
			i1_s1   <= cft_pkg::reduce_idx(in_data.key_hash[31:0], idx_bits);
			prod_s1 <= 32'({16'd0, fp_c} * cft_pkg::ALT_MULT);
		end
	end

	// second stage output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_valid <= 1'b0;
		end else if (q_ready || !q_valid) begin
			q_valid <= v_s1 && adv;
		end
	end

	always_ff @(posedge clk) begin
		if (q_ready || !q_valid) begin
			q_data.action <= act_s1;
			q_data.fp     <= fp_s1;
			q_data.i1     <= i1_s1;
			q_data.i2     <= cft_pkg::reduce_idx({22'd0, i1_s1} ^ prod_s1, idx_bits);
		end
	end
endmodule

>>> src/cft_queue.sv
module cft_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  cft_pkg::cmd_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output cft_pkg::cmd_t rd_data
);
	// two-entry fifo between front and back
	cft_pkg::cmd_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

>>> src/cft_back.sv
module cft_back (
	input  logic          clk,
	input  logic          arst_n,
	input  cft_pkg::cfg_t cfg,
	input  logic          c_valid,
	output logic          c_ready,
	input  cft_pkg::cmd_t c_data,
	output logic          out_valid,
	input  logic          out_ready,
	output cft_pkg::rsp_t out_data
);
	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_RD1   = 4'd2;
	localparam logic [3:0] ST_CHK1  = 4'd3;
	localparam logic [3:0] ST_CHK2  = 4'd4;
	localparam logic [3:0] ST_KSEL  = 4'd5;
	localparam logic [3:0] ST_KRD   = 4'd6;
	localparam logic [3:0] ST_KWR   = 4'd7;
	localparam logic [3:0] ST_KMUL  = 4'd8;
	localparam logic [3:0] ST_KALT  = 4'd9;
	localparam logic [3:0] ST_KCHK  = 4'd10;
	localparam logic [3:0] ST_DONE  = 4'd11;

	localparam int BB = cft_pkg::BucketBits;
	localparam int FB = cft_pkg::FpBits;

	// one row per bucket, all slots side by side
	logic [cft_pkg::RowBits-1:0] mem [cft_pkg::NumBuckets];
	logic [cft_pkg::RowBits-1:0] rdata_q;
	logic [BB-1:0]  raddr, waddr;
	logic           we;
	logic [cft_pkg::RowBits-1:0] wdata;

	logic [3:0]     state_q;
	cft_pkg::cmd_t  cmd_q;
	logic [FB-1:0]  fp_q;
	logic [BB-1:0]  cur_q;
	logic [cft_pkg::SlotBits-1:0] slot_q;
	logic [cft_pkg::KickBits-1:0] kick_q;
	logic [15:0]    lfsr_q;
	logic [cft_pkg::CountBits-1:0] count_q;
	logic [31:0]    prod_q;
	logic           ok_q;
	logic [BB-1:0]  clr_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// slot scan on the fetched row
	logic [cft_pkg::Slots-1:0] hit, empty;
	logic [cft_pkg::SlotBits-1:0] hit_s, empty_s;
	always_comb begin
		hit_s = '0;
		empty_s = '0;
		for (int s = cft_pkg::Slots - 1; s >= 0; s--) begin
			hit[s]   = rdata_q[s*FB +: FB] == fp_q;
			empty[s] = rdata_q[s*FB +: FB] == '0;
			if (hit[s]) hit_s = cft_pkg::SlotBits'(s);
			if (empty[s]) empty_s = cft_pkg::SlotBits'(s);
		end
	end

	function automatic logic [cft_pkg::RowBits-1:0] put(
			input logic [cft_pkg::RowBits-1:0] row,
			input logic [cft_pkg::SlotBits-1:0] s, input logic [FB-1:0] v);
		logic [cft_pkg::RowBits-1:0] r;
		r = row;
		r[s*FB +: FB] = v;
		return r;
	endfunction

	logic [15:0] lfsr_n;
	assign lfsr_n = cft_pkg::lfsr_step(lfsr_q);

	assign c_ready   = state_q == ST_IDLE;
	assign out_valid = state_q == ST_DONE;
	assign out_data.success    = ok_q;
	assign out_data.item_count = count_q;

	always_comb begin
		raddr = cur_q;
		we    = 1'b0;
		waddr = cur_q;
		wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
			end
			ST_IDLE: raddr = c_data.i1;
			ST_RD1: raddr = cmd_q.i1;
			ST_CHK1: begin
				raddr = cmd_q.i2;
				if ((cmd_q.action == cft_pkg::ACT_INSERT) && (|empty)) begin
					we = 1'b1;
					waddr = cmd_q.i1;
					wdata = put(rdata_q, empty_s, fp_q);
				end else if ((cmd_q.action == cft_pkg::ACT_REMOVE) && (|hit)) begin
					we = 1'b1;
					waddr = cmd_q.i1;
					wdata = put(rdata_q, hit_s, '0);
				end
			end
			ST_CHK2: begin
				waddr = cmd_q.i2;
				if ((cmd_q.action == cft_pkg::ACT_INSERT) && (|empty)) begin
					we = 1'b1;
					wdata = put(rdata_q, empty_s, fp_q);
				end else if ((cmd_q.action == cft_pkg::ACT_REMOVE) && (|hit)) begin
					we = 1'b1;
					wdata = put(rdata_q, hit_s, '0);
				end
			end
			ST_KWR: begin
				we = 1'b1;
				wdata = put(rdata_q, slot_q, fp_q);
			end
			// fetch the alternate bucket of the displaced fingerprint
			ST_KALT: raddr = cft_pkg::reduce_idx({22'd0, cur_q} ^ prod_q, cfg.idx_bits);
			ST_KCHK: begin
				if (|empty) begin
					we = 1'b1;
					wdata = put(rdata_q, empty_s, fp_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			lfsr_q  <= cft_pkg::SEED_RESET;
		end else begin
			if (cfg.seed_load) lfsr_q <= (cfg.seed == 16'd0) ? 16'd1 : cfg.seed;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BB'(cft_pkg::NumBuckets - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (c_valid) state_q <= ST_RD1;
				ST_RD1: state_q <= ST_CHK1;
				ST_CHK1: begin
					if (cmd_q.action == cft_pkg::ACT_INSERT && (|empty)) begin
						if (count_q != cft_pkg::COUNT_MAX) count_q <= count_q + 1'b1;
						state_q <= ST_DONE;
					end else if (cmd_q.action == cft_pkg::ACT_REMOVE && (|hit)) begin
						if (count_q != '0) count_q <= count_q - 1'b1;
						state_q <= ST_DONE;
					end else if (cmd_q.action == cft_pkg::ACT_LOOKUP && (|hit)) begin
						state_q <= ST_DONE;
					end else if (cmd_q.action != cft_pkg::ACT_INSERT &&
							cmd_q.action != cft_pkg::ACT_LOOKUP &&
							cmd_q.action != cft_pkg::ACT_REMOVE) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_CHK2;
					end
				end
				ST_CHK2: begin
					if (cmd_q.action == cft_pkg::ACT_INSERT) begin
						if (|empty) begin
							if (count_q != cft_pkg::COUNT_MAX) count_q <= count_q + 1'b1;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_KSEL;
						end
					end else begin
						if (cmd_q.action == cft_pkg::ACT_REMOVE && (|hit) && count_q != '0)
							count_q <= count_q - 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_KSEL: begin
					lfsr_q <= lfsr_n;
					state_q <= ST_KRD;
				end
				ST_KRD: begin
					lfsr_q <= lfsr_n;
					state_q <= ST_KWR;
				end
				ST_KWR: state_q <= ST_KMUL;
				ST_KMUL: state_q <= ST_KALT;
				ST_KALT: state_q <= ST_KCHK;
				ST_KCHK: begin
					if (|empty) begin
						if (count_q != cft_pkg::COUNT_MAX) count_q <= count_q + 1'b1;
						state_q <= ST_DONE;
					end else if (kick_q == cft_pkg::KickBits'(cft_pkg::KickLimit - 1)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_KRD;
					end
				end
				ST_DONE: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q  <= c_data;
				fp_q   <= c_data.fp;
				ok_q   <= 1'b0;
				kick_q <= '0;
			end
			ST_CHK1: ok_q <= (cmd_q.action == cft_pkg::ACT_INSERT) ? (|empty) :
				(cmd_q.action == cft_pkg::ACT_LOOKUP || cmd_q.action == cft_pkg::ACT_REMOVE)
				? (|hit) : 1'b0;
			ST_CHK2: ok_q <= (cmd_q.action == cft_pkg::ACT_INSERT) ? (|empty) : (|hit);
			ST_KSEL: cur_q <= lfsr_n[0] ? cmd_q.i1 : cmd_q.i2;
			ST_KRD: slot_q <= cft_pkg::SlotBits'(lfsr_n);
			ST_KWR: begin
				fp_q <= rdata_q[slot_q*FB +: FB];
			end
			ST_KMUL: prod_q <= 32'({16'd0, fp_q} * cft_pkg::ALT_MULT);
			ST_KALT: cur_q <= cft_pkg::reduce_idx({22'd0, cur_q} ^ prod_q, cfg.idx_bits);
			ST_KCHK: begin
				ok_q   <= |empty;
				kick_q <= kick_q + 1'b1;
			end
			default: ;
		endcase
	end
endmodule

>>> tb/sv/cuckoo_filter_table_tb.sv
module cuckoo_filter_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	cft_pkg::req_t in_data;
	logic          out_valid;
	logic          out_ready;
	cft_pkg::rsp_t out_data;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [0:0]    cfg_index;
	logic [15:0]   cfg_data;

	cuckoo_filter_table uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// filter shadow state
	logic [cft_pkg::FpBits-1:0]    shadow_tab [cft_pkg::NumBuckets*cft_pkg::Slots];
	logic [cft_pkg::CountBits-1:0] shadow_count;
	logic [15:0]                   shadow_lfsr;
	logic [3:0]                    shadow_idx_bits;

	cft_pkg::rsp_t pending_rsp[$];
	int            mismatches;
	bit            hold_go;
	logic [63:0]   key_pool[$];

	typedef struct {
		logic [1:0]  action;
		logic [63:0] key;
		bit          typed;
		logic        success;
		logic [cft_pkg::CountBits-1:0] count;
	} row_t;
	row_t rows[$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [cft_pkg::BucketBits-1:0] bucket_of(input logic [63:0] v);
		logic [63:0] m;
		m = (64'd1 << shadow_idx_bits) - 64'd1;
		return cft_pkg::BucketBits'(v & m);
	endfunction

	function automatic logic [cft_pkg::BucketBits-1:0] alt_of(
			input logic [cft_pkg::BucketBits-1:0] b,
			input logic [cft_pkg::FpBits-1:0] fp);
		return bucket_of({54'd0, b} ^ (64'(fp) * 64'(cft_pkg::ALT_MULT)));
	endfunction

	function automatic logic [15:0] lfsr_advance();
		shadow_lfsr = shadow_lfsr[0] ? ((shadow_lfsr >> 1) ^ cft_pkg::LFSR_TAPS) :
			(shadow_lfsr >> 1);
		return shadow_lfsr;
	endfunction

	function automatic bit take_free(input logic [cft_pkg::BucketBits-1:0] b,
			input logic [cft_pkg::FpBits-1:0] fp);
		for (int s = 0; s < cft_pkg::Slots; s++) begin
			if (shadow_tab[b*cft_pkg::Slots+s] == '0) begin
				shadow_tab[b*cft_pkg::Slots+s] = fp;
				if (shadow_count != cft_pkg::COUNT_MAX) shadow_count++;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic int slot_of(input logic [cft_pkg::BucketBits-1:0] b,
			input logic [cft_pkg::FpBits-1:0] fp);
		for (int s = 0; s < cft_pkg::Slots; s++)
			if (shadow_tab[b*cft_pkg::Slots+s] == fp) return s;
		return -1;
	endfunction

	// filter behavior for one request, updates shadow state
	function automatic cft_pkg::rsp_t filter_result(input logic [1:0] act,
			input logic [63:0] key);
		logic [cft_pkg::FpBits-1:0]     fp, kicked;
		logic [cft_pkg::BucketBits-1:0] b1, b2, cur;
		logic [15:0]   lv;
		int            s;
		bit            ok;
		cft_pkg::rsp_t r;
		fp = key[15:0];
		if (fp == '0) fp = 16'd1;
		b1 = bucket_of(key);
		b2 = alt_of(b1, fp);
		ok = 1'b0;
		case (act)
			cft_pkg::ACT_INSERT: begin
				if (take_free(b1, fp) || take_free(b2, fp)) begin
					ok = 1'b1;
				end else begin
					lv = lfsr_advance();
					cur = lv[0] ? b1 : b2;
					for (int n = 0; n < cft_pkg::KickLimit && !ok; n++) begin
						s = int'(lfsr_advance() % cft_pkg::Slots);
						kicked = shadow_tab[cur*cft_pkg::Slots+s];
						shadow_tab[cur*cft_pkg::Slots+s] = fp;
						fp = kicked;
						cur = alt_of(cur, fp);
						ok = take_free(cur, fp);
					end
				end
			end
			cft_pkg::ACT_LOOKUP: ok = slot_of(b1, fp) >= 0 || slot_of(b2, fp) >= 0;
			cft_pkg::ACT_REMOVE: begin
				cur = b1;
				s = slot_of(b1, fp);
				if (s < 0) begin
					cur = b2;
					s = slot_of(b2, fp);
				end
				if (s >= 0) begin
					shadow_tab[cur*cft_pkg::Slots+s] = '0;
					if (shadow_count != '0) shadow_count--;
					ok = 1'b1;
				end
			end
			default: ok = 1'b0;
		endcase
		r.success = ok;
		r.item_count = shadow_count;
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		cft_pkg::rsp_t want;
		if (out_valid && out_ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result success=%0d count=%0d",
						out_data.success, out_data.item_count);
			end else begin
				want = pending_rsp.pop_front();
				if (want.success !== out_data.success ||
						want.item_count !== out_data.item_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected success=%0d count=%0d, got %0d %0d",
							want.success, want.item_count,
							out_data.success, out_data.item_count);
				end
			end
		end
	end

	// receiver stall pattern plus one long hold-off
	initial begin
		int  mode;
		bit  hold_done;
		hold_done = 1'b0;
		mode = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_done = 1'b1;
			end
			if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 3);
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 0);
				2: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	int burst_left;

	// one request transfer; leaves valid high after acceptance
	task automatic send_req(input logic [1:0] act, input logic [63:0] key,
			input bit typed, input logic ok, input logic [cft_pkg::CountBits-1:0] cnt);
		cft_pkg::rsp_t r;
		if (burst_left == 0) begin
			if ($urandom_range(0, 9) < 7) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data.action <= act;
		in_data.key_hash <= key;
		@(posedge clk iff in_ready);
		r = filter_result(act, key);
		if (typed) begin
			r.success = ok;
			r.item_count = cnt;
		end
		pending_rsp.push_back(r);
	endtask

	task automatic add_row(input logic [1:0] act, input logic [63:0] key,
			input bit typed, input logic ok, input logic [cft_pkg::CountBits-1:0] cnt);
		row_t rw;
		rw.action = act;
		rw.key = key;
		rw.typed = typed;
		rw.success = ok;
		rw.count = cnt;
		rows.push_back(rw);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk iff cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == cft_pkg::CFG_IDX_BITS) begin
			shadow_idx_bits = val[3:0];
		end else begin
			shadow_lfsr = (val == '0) ? 16'd1 : val;
		end
	endtask

	function automatic logic [63:0] rand_key();
		logic [63:0] k;
		k = {$urandom, $urandom};
		if ($urandom_range(0, 29) == 0) k[15:0] = '0;
		return k;
	endfunction

	initial begin
		logic [3:0]  ph_bits[6];
		logic [15:0] ph_seed[6];
		int          ph_items[6];
		logic [1:0]  act;
		logic [63:0] key;
		int          r;

		ph_bits = '{4'd10, 4'd2, 4'd0, 4'd15, 4'd4, 4'd10};
		ph_seed = '{16'd0, 16'd65535, 16'd1, 16'd12345, 16'd0, 16'd44257};
		ph_items = '{500, 60, 30, 300, 150, 200};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = cft_pkg::CFG_IDX_BITS;
		cfg_data = '0;
		mismatches = 0;
		hold_go = 1'b0;
		burst_left = 0;
		for (int i = 0; i < cft_pkg::NumBuckets*cft_pkg::Slots; i++) shadow_tab[i] = '0;
		shadow_count = '0;
		shadow_lfsr = cft_pkg::SEED_RESET;
		shadow_idx_bits = cft_pkg::IDX_BITS_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows at reset configuration
		add_row(cft_pkg::ACT_LOOKUP, 64'd0, 1, 1'b0, 13'd0);
		add_row(cft_pkg::ACT_REMOVE, 64'd0, 1, 1'b0, 13'd0);
		add_row(cft_pkg::ACT_INSERT, 64'd0, 1, 1'b1, 13'd1);
		add_row(cft_pkg::ACT_LOOKUP, 64'd0, 1, 1'b1, 13'd1);
		add_row(cft_pkg::ACT_LOOKUP, 64'd1, 0, 1'b0, 13'd0);
		add_row(2'd3, '1, 1, 1'b0, 13'd1);
		add_row(cft_pkg::ACT_INSERT, '1, 1, 1'b1, 13'd2);
		add_row(cft_pkg::ACT_REMOVE, '1, 1, 1'b1, 13'd1);
		add_row(cft_pkg::ACT_LOOKUP, '1, 1, 1'b0, 13'd1);
		add_row(cft_pkg::ACT_INSERT, 64'h0000_0000_0001_0000, 0, 1'b0, 13'd0);
		// same fingerprint and buckets until both fill and the kick walk gives up
		for (int i = 0; i < 8; i++) add_row(cft_pkg::ACT_INSERT, 64'd0, 0, 1'b0, 13'd0);
		add_row(cft_pkg::ACT_LOOKUP, 64'h8000_0000_0000_0000, 0, 1'b0, 13'd0);
		add_row(cft_pkg::ACT_REMOVE, 64'd0, 0, 1'b0, 13'd0);
		add_row(cft_pkg::ACT_INSERT, 64'hA5A5_5A5A_0F0F_F0F0, 0, 1'b0, 13'd0);
		add_row(cft_pkg::ACT_REMOVE, 64'h5A5A_A5A5_F0F0_0F0F, 0, 1'b0, 13'd0);
		foreach (rows[i]) send_req(rows[i].action, rows[i].key, rows[i].typed,
			rows[i].success, rows[i].count);
		drain();

		// random phases across register settings
		for (int p = 0; p < 6; p++) begin
			write_reg(cft_pkg::CFG_IDX_BITS, {12'd0, ph_bits[p]});
			write_reg(cft_pkg::CFG_SEED, (p == 3) ? 16'($urandom) : ph_seed[p]);
			if (p == 0) hold_go = 1'b1;
			for (int n = 0; n < ph_items[p]; n++) begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					act = 2'd3;
					key = rand_key();
				end else begin
					act = (r < 45) ? cft_pkg::ACT_INSERT :
						(r < 75) ? cft_pkg::ACT_LOOKUP : cft_pkg::ACT_REMOVE;
					if (act != cft_pkg::ACT_INSERT && key_pool.size() != 0 &&
							$urandom_range(0, 9) < 7) begin
						key = key_pool[$urandom_range(0, key_pool.size() - 1)];
					end else begin
						key = rand_key();
					end
					if (act == cft_pkg::ACT_INSERT) begin
						key_pool.push_back(key);
						if (key_pool.size() > 64) void'(key_pool.pop_front());
					end
				end
				send_req(act, key, 0, 1'b0, '0);
			end
			drain();
		end

		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
